[hdl/lirb_pkg.sv]
`default_nettype none

package lirb_pkg;

    // Field widths of the stream items.
    localparam int unsigned ADDR_IN_W = 17;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned WIDTH_W   = 9;
    localparam int unsigned HEIGHT_W  = 8;

    // Bus widths.
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned PDATA_W   = 32;

    // Blend arithmetic.
    localparam int unsigned WT_W       = 16;
    localparam int unsigned PROD_W     = PIX_W + WT_W;
    localparam int unsigned SUM_W      = PROD_W + 2;
    localparam logic [WT_W-1:0]  WEIGHT_ONE = 16'hFFFF;
    localparam logic [SUM_W-1:0] ROUND_HALF = 26'd32768;
    localparam int unsigned SUM_SHIFT  = 16;

    // Front queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // Register map, index is paddr[3:2].
    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_INTERP = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic                RST_INTERP = 1'b1;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 9'd256;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 8'd128;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_REMAP = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [ADDR_IN_W-1:0] load_addr;
        logic [PIX_W-1:0]     load_byte;
        logic [COORD_W-1:0]   coord_x;
        logic [COORD_W-1:0]   coord_y;
    } t_item;

    typedef struct packed {
        logic                interp_enable;
        logic [WIDTH_W-1:0]  map_width;
        logic [HEIGHT_W-1:0] map_height;
    } t_cfg;

endpackage

`default_nettype wire

[hdl/lut_image_remap_bilinear.sv]
// Path: a remap transfer goes through the 4-entry front queue, then the
//   back pipeline stages A to E and the output register, to m_tdata.
// Throughput: one item per cycle while m_tready does not hold the back pipeline;
//   the store has two copies with two read ports each, so all four taps of a pixel are read in one cycle.
// Reset: synchronous active-low; clears the queue, pipeline valid bits and
//   sets the registers to bilinear mode, 256 by 128. The store is not cleared.
`default_nettype none

module lut_image_remap_bilinear #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 128,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // [16:0] load_addr, [24:17] load_byte, [40:25] coord_x, [56:41] coord_y
    input  wire [lirb_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] func
    input  wire                                s_tuser,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [7:0] out_pixel, [24:8] base_index
    output logic [lirb_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [lirb_pkg::PADDR_W-1:0]        paddr,
    input  wire [lirb_pkg::PDATA_W-1:0]        pwdata,
    output logic [lirb_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int unsigned STORE_DEPTH = 4 * MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

    logic                                r_interp;
    logic [lirb_pkg::WIDTH_W-1:0]        r_width;
    logic [lirb_pkg::HEIGHT_W-1:0]       r_height;
    logic [lirb_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                cfg_wr;
    lirb_pkg::t_cfg                      cfg;
    lirb_pkg::t_item                     item;
    logic                                item_vld;
    logic                                pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lirb_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes on the access phase of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp <= lirb_pkg::RST_INTERP;
            r_width  <= lirb_pkg::RST_WIDTH;
            r_height <= lirb_pkg::RST_HEIGHT;
        end else if (cfg_wr) begin
            case (reg_idx)
                lirb_pkg::REG_INTERP: r_interp <= pwdata[0];
                lirb_pkg::REG_WIDTH:  r_width  <= pwdata[lirb_pkg::WIDTH_W-1:0];
                lirb_pkg::REG_HEIGHT: r_height <= pwdata[lirb_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            lirb_pkg::REG_INTERP: prdata = lirb_pkg::PDATA_W'(r_interp);
            lirb_pkg::REG_WIDTH:  prdata = lirb_pkg::PDATA_W'(r_width);
            lirb_pkg::REG_HEIGHT: prdata = lirb_pkg::PDATA_W'(r_height);
            default:              prdata = '0;
        endcase
    end

    assign cfg.interp_enable = r_interp;
    assign cfg.map_width     = r_width;
    assign cfg.map_height    = r_height;

    lirb_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_item     (item),
        .o_item_vld (item_vld),
        .i_pop      (pop)
    );

    lirb_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_item     (item),
        .i_item_vld (item_vld),
        .o_pop      (pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[hdl/lirb_front.sv]
`default_nettype none

module lirb_front #(
    parameter int unsigned STORE_DEPTH = 131072
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // [16:0] load_addr, [24:17] load_byte, [40:25] coord_x, [56:41] coord_y
    input  wire [lirb_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // [0] func
    input  wire                                i_s_tuser,
    output lirb_pkg::t_item                    o_item,
    output logic                               o_item_vld,
    input  wire                                i_pop
);

    lirb_pkg::t_item r_q [lirb_pkg::QUEUE_DEPTH];
    logic [lirb_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [lirb_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [lirb_pkg::QCNT_W-1:0] r_count;
    lirb_pkg::t_item n_item;
    logic            keep;
    logic            push;
    logic            pop;

    // Decode the transfer into an item; loads past the store are dropped here.
    always_comb begin
        n_item.kind      = i_s_tuser ? lirb_pkg::KIND_REMAP : lirb_pkg::KIND_LOAD;
        n_item.load_addr = i_s_tdata[16:0];
        n_item.load_byte = i_s_tdata[24:17];
        n_item.coord_x   = i_s_tdata[40:25];
        n_item.coord_y   = i_s_tdata[56:41];
        keep = (n_item.kind == lirb_pkg::KIND_REMAP) ||
               (32'(n_item.load_addr) < STORE_DEPTH);
    end

    assign o_s_tready = (r_count != lirb_pkg::QCNT_W'(lirb_pkg::QUEUE_DEPTH));
    assign o_item_vld = (r_count != '0);
    assign o_item     = r_q[r_rd_ptr];
    assign push       = i_s_tvalid && o_s_tready && keep;
    assign pop        = i_pop && o_item_vld;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lirb_pkg::QCNT_W'(lirb_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

[hdl/lirb_store.sv]
`default_nettype none

module lirb_store #(
    parameter int unsigned DEPTH  = 131072,
    parameter int unsigned ADDR_W = 17
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [ADDR_W-1:0]          i_waddr,
    input  wire [lirb_pkg::PIX_W-1:0] i_wdata,
    input  wire                       i_re,
    input  wire [ADDR_W-1:0]          i_raddr1,
    input  wire [ADDR_W-1:0]          i_raddr2,
    input  wire [ADDR_W-1:0]          i_raddr3,
    input  wire [ADDR_W-1:0]          i_raddr4,
    output logic [lirb_pkg::PIX_W-1:0] o_q1,
    output logic [lirb_pkg::PIX_W-1:0] o_q2,
    output logic [lirb_pkg::PIX_W-1:0] o_q3,
    output logic [lirb_pkg::PIX_W-1:0] o_q4
);

    // Two copies of the image, each with two read ports, give four taps a cycle.
    logic [lirb_pkg::PIX_W-1:0] r_mem_a [DEPTH];
    logic [lirb_pkg::PIX_W-1:0] r_mem_b [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_a[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_q1 <= r_mem_a[i_raddr1];
            o_q2 <= r_mem_a[i_raddr2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_b[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_q3 <= r_mem_b[i_raddr3];
            o_q4 <= r_mem_b[i_raddr4];
        end
    end

endmodule

`default_nettype wire

[hdl/lirb_back.sv]
`default_nettype none

module lirb_back #(
    parameter int unsigned STORE_DEPTH = 131072,
    parameter int unsigned ADDR_W      = 17,
    parameter int unsigned FRAC_BITS   = 8
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  lirb_pkg::t_cfg                    i_cfg,
    input  lirb_pkg::t_item                   i_item,
    input  wire                               i_item_vld,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // [7:0] out_pixel, [24:8] base_index
    output logic [lirb_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    localparam int unsigned F     = FRAC_BITS;
    localparam int unsigned IW    = lirb_pkg::COORD_W - F;
    localparam int unsigned P_W   = 2 * F + 1;
    localparam int unsigned YW_W  = IW + lirb_pkg::WIDTH_W;
    localparam int unsigned WH_W  = lirb_pkg::WIDTH_W + lirb_pkg::HEIGHT_W;
    localparam int unsigned CW_A  = YW_W + 3;
    localparam int unsigned CW_B  = WH_W + 2;
    localparam int unsigned CW_C  = ADDR_W + 1;
    localparam int unsigned CW_AB = (CW_A > CW_B) ? CW_A : CW_B;
    localparam int unsigned CMP_W = (CW_AB > CW_C) ? CW_AB : CW_C;
    localparam logic [F:0]  ONE_V = {1'b1, {F{1'b0}}};

    logic adv;

    // Stage A: item taken from the queue.
    logic                             r_a_vld;
    lirb_pkg::t_kind                  r_a_kind;
    logic [ADDR_W-1:0]                r_a_waddr;
    logic [lirb_pkg::PIX_W-1:0]       r_a_byte;
    logic [lirb_pkg::COORD_W-1:0]     r_a_cx;
    logic [lirb_pkg::COORD_W-1:0]     r_a_cy;

    // Stage B: row product, image size and raw weight products.
    logic                             r_b_vld;
    lirb_pkg::t_kind                  r_b_kind;
    logic [ADDR_W-1:0]                r_b_waddr;
    logic [lirb_pkg::PIX_W-1:0]       r_b_byte;
    logic [IW-1:0]                    r_b_xi;
    logic [YW_W-1:0]                  r_b_yw;
    logic [WH_W-1:0]                  r_b_wh;
    logic [P_W-1:0]                   r_b_pw [4];

    // Stage C: unclamped indices, index limit and 16-bit weights.
    logic                             r_c_vld;
    lirb_pkg::t_kind                  r_c_kind;
    logic [ADDR_W-1:0]                r_c_waddr;
    logic [lirb_pkg::PIX_W-1:0]       r_c_byte;
    logic [CMP_W-1:0]                 r_c_raw;
    logic [CMP_W-1:0]                 r_c_r3;
    logic [CMP_W-1:0]                 r_c_lim;
    logic [lirb_pkg::WT_W-1:0]        r_c_w [4];

    // Stage D: store read in flight.
    logic                             r_d_vld;
    logic [ADDR_W-1:0]                r_d_base;
    logic [lirb_pkg::WT_W-1:0]        r_d_w [4];

    // Stage E: weighted taps.
    logic                             r_e_vld;
    logic [ADDR_W-1:0]                r_e_base;
    logic [lirb_pkg::PIX_W-1:0]       r_e_near;
    logic [lirb_pkg::PROD_W-1:0]      r_e_m [4];

    // Output register.
    logic                             r_out_vld;
    logic [lirb_pkg::PIX_W-1:0]       r_out_pixel;
    logic [ADDR_W-1:0]                r_out_base;

    logic [lirb_pkg::PIX_W-1:0]       q [4];
    logic [IW-1:0]                    xi;
    logic [IW-1:0]                    yi;
    logic [F:0]                       fx;
    logic [F:0]                       fy;
    logic [F:0]                       gx;
    logic [F:0]                       gy;
    logic [2*F+1:0]                   t_pw [4];
    logic [YW_W-1:0]                  n_b_yw;
    logic [WH_W-1:0]                  n_b_wh;
    logic [CMP_W-1:0]                 yw_c;
    logic [CMP_W-1:0]                 xi_c;
    logic [CMP_W-1:0]                 idx_n;
    logic [CMP_W-1:0]                 raw_b;
    logic [CMP_W-1:0]                 cnt_n;
    logic [CMP_W-1:0]                 n_c_raw;
    logic [CMP_W-1:0]                 n_c_r3;
    logic [CMP_W-1:0]                 n_c_lim;
    logic [P_W+lirb_pkg::WT_W-1:0]    t_w [4];
    logic [CMP_W-1:0]                 d1;
    logic [CMP_W-1:0]                 d2;
    logic [CMP_W-1:0]                 d3;
    logic [CMP_W-1:0]                 d4;
    logic                             we;
    logic [lirb_pkg::SUM_W-1:0]       sum;

    // Last valid index for an image of cnt pixels held in the store.
    function automatic logic [CMP_W-1:0] f_lim(input logic [CMP_W-1:0] cnt);
        logic [CMP_W-1:0] lim;
        if (cnt == '0) begin
            lim = '0;
        end else if (cnt > CMP_W'(STORE_DEPTH)) begin
            lim = CMP_W'(STORE_DEPTH - 1);
        end else begin
            lim = cnt - 1'b1;
        end
        return lim;
    endfunction

    // The whole back pipeline moves when the output register can take a result.
    assign adv   = !r_out_vld || i_m_tready;
    assign o_pop = adv;

    // Stage B logic: split the coordinate and form the products.
    always_comb begin
        xi = r_a_cx[lirb_pkg::COORD_W-1:F];
        yi = r_a_cy[lirb_pkg::COORD_W-1:F];
        fx = {1'b0, r_a_cx[F-1:0]};
        fy = {1'b0, r_a_cy[F-1:0]};
        gx = ONE_V - fx;
        gy = ONE_V - fy;
        t_pw[0] = gx * gy;
        t_pw[1] = fx * gy;
        t_pw[2] = gx * fy;
        t_pw[3] = fx * fy;
        n_b_yw = i_cfg.map_width * yi;
        n_b_wh = i_cfg.map_width * i_cfg.map_height;
    end

    // Stage C logic: indices in the selected image layout and scaled weights.
    always_comb begin
        yw_c  = CMP_W'(r_b_yw);
        xi_c  = CMP_W'(r_b_xi);
        cnt_n = CMP_W'(r_b_wh);
        idx_n = yw_c + xi_c;
        raw_b = (yw_c << 2) + (xi_c << 1);
        if (i_cfg.interp_enable) begin
            n_c_raw = raw_b;
            n_c_r3  = raw_b + (CMP_W'(i_cfg.map_width) << 1);
            n_c_lim = f_lim(cnt_n << 2);
        end else begin
            n_c_raw = idx_n;
            n_c_r3  = idx_n;
            n_c_lim = f_lim(cnt_n);
        end
        for (int k = 0; k < 4; k++) begin
            t_w[k] = r_b_pw[k] * lirb_pkg::WEIGHT_ONE;
        end
    end

    // Stage D logic: clamp the four taps to the last index.
    always_comb begin
        d1 = (r_c_raw > r_c_lim) ? r_c_lim : r_c_raw;
        d2 = (r_c_raw < r_c_lim) ? r_c_raw + 1'b1 : r_c_lim;
        d3 = (r_c_r3 > r_c_lim) ? r_c_lim : r_c_r3;
        d4 = (r_c_r3 < r_c_lim) ? r_c_r3 + 1'b1 : r_c_lim;
        we = adv && r_c_vld && (r_c_kind == lirb_pkg::KIND_LOAD);
    end

    lirb_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (r_c_waddr),
        .i_wdata  (r_c_byte),
        .i_re     (adv),
        .i_raddr1 (ADDR_W'(d1)),
        .i_raddr2 (ADDR_W'(d2)),
        .i_raddr3 (ADDR_W'(d3)),
        .i_raddr4 (ADDR_W'(d4)),
        .o_q1     (q[0]),
        .o_q2     (q[1]),
        .o_q3     (q[2]),
        .o_q4     (q[3])
    );

    // Output logic: rounded blend of the four weighted taps.
    assign sum = lirb_pkg::SUM_W'(r_e_m[0]) + lirb_pkg::SUM_W'(r_e_m[1]) +
                 lirb_pkg::SUM_W'(r_e_m[2]) + lirb_pkg::SUM_W'(r_e_m[3]) +
                 lirb_pkg::ROUND_HALF;

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_kind  <= i_item.kind;
            r_a_waddr <= ADDR_W'(i_item.load_addr);
            r_a_byte  <= i_item.load_byte;
            r_a_cx    <= i_item.coord_x;
            r_a_cy    <= i_item.coord_y;

            r_b_kind  <= r_a_kind;
            r_b_waddr <= r_a_waddr;
            r_b_byte  <= r_a_byte;
            r_b_xi    <= xi;
            r_b_yw    <= n_b_yw;
            r_b_wh    <= n_b_wh;

            r_c_kind  <= r_b_kind;
            r_c_waddr <= r_b_waddr;
            r_c_byte  <= r_b_byte;
            r_c_raw   <= n_c_raw;
            r_c_r3    <= n_c_r3;
            r_c_lim   <= n_c_lim;

            r_d_base  <= ADDR_W'(d1);

            r_e_base  <= r_d_base;
            r_e_near  <= q[0];

            r_out_pixel <= i_cfg.interp_enable ?
                           sum[lirb_pkg::SUM_SHIFT +: lirb_pkg::PIX_W] : r_e_near;
            r_out_base  <= r_e_base;

            for (int k = 0; k < 4; k++) begin
                r_b_pw[k] <= t_pw[k][P_W-1:0];
                r_c_w[k]  <= t_w[k][2*F +: lirb_pkg::WT_W];
                r_d_w[k]  <= r_c_w[k];
                r_e_m[k]  <= q[k] * r_d_w[k];
            end
        end
    end

    // Pipeline valid bits; only remap items travel past the store stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld   <= i_item_vld;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld && (r_c_kind == lirb_pkg::KIND_REMAP);
            r_e_vld   <= r_d_vld;
            r_out_vld <= r_e_vld;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(lirb_pkg::M_TDATA_W - lirb_pkg::ADDR_IN_W - lirb_pkg::PIX_W){1'b0}},
                         lirb_pkg::ADDR_IN_W'(r_out_base), r_out_pixel};

    a_tap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> ((d2 <= r_c_lim) && (d4 <= r_c_lim) && (d1 <= d2) && (d3 <= d4)))
        else $error("clamped tap outside the image");

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> ((18'(r_c_w[0]) + 18'(r_c_w[1]) + 18'(r_c_w[2]) + 18'(r_c_w[3]))
                     <= 18'(lirb_pkg::WEIGHT_ONE)))
        else $error("blend weights exceed unity");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_vld && !adv) |=> (r_d_vld && $stable(r_d_base)))
        else $error("store stage moved during a stall");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lirb_pkg::*;

    localparam int unsigned MAP_MAX_W    = 256;
    localparam int unsigned MAP_MAX_H    = 128;
    localparam int unsigned FRAC         = 8;
    localparam int unsigned STORE_DEPTH  = 4 * MAP_MAX_W * MAP_MAX_H;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned NUM_DIR      = 25;
    localparam int unsigned NUM_FIXED    = 9;
    localparam int unsigned NUM_PHASES   = 12;
    localparam int unsigned ITEMS_PER_PHASE = 88;

    // Register settings visited by the random phases, extremes first.
    localparam logic PHASE_INTERP [NUM_FIXED] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                                 1'b1, 1'b0};
    localparam logic [WIDTH_W-1:0] PHASE_W [NUM_FIXED] = '{9'd256, 9'd256, 9'd1, 9'd1, 9'd2,
                                                          9'd0, 9'd9, 9'd511, 9'd511};
    localparam logic [HEIGHT_W-1:0] PHASE_H [NUM_FIXED] = '{8'd128, 8'd128, 8'd1, 8'd1, 8'd3,
                                                           8'd7, 8'd0, 8'd255, 8'd255};

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_REMAP
    } t_row_op;

    typedef struct packed {
        t_row_op              op;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [31:0]          value;
        logic [ADDR_IN_W-1:0] addr;
        logic [PIX_W-1:0]     data;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic                 typed;
        logic [PIX_W-1:0]     pix;
        logic [ADDR_IN_W-1:0] base;
    } t_row;

    typedef struct packed {
        logic [PIX_W-1:0]     pix;
        logic [ADDR_IN_W-1:0] base;
    } t_result;

    typedef logic [3:0][ADDR_IN_W-1:0] t_taps;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // [16:0] load_addr, [24:17] load_byte, [40:25] coord_x, [56:41] coord_y
    logic [S_TDATA_W-1:0] s_tdata;
    // [0] func
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // [7:0] out_pixel, [24:8] base_index
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Local copy of the block's state: source bytes, which ones were loaded, registers.
    logic [PIX_W-1:0]     src_copy [STORE_DEPTH];
    bit                   stored [STORE_DEPTH];
    t_cfg                 model_cfg;

    t_result              pending_px [$];
    int                   n_mismatch = 0;
    int                   n_checked = 0;
    int                   n_loads = 0;
    int                   n_remaps = 0;
    int                   n_settings = 0;
    int                   burst_left = 0;
    logic [ADDR_IN_W-1:0] last_tap = '0;

    lut_image_remap_bilinear #(
        .MAX_WIDTH (MAP_MAX_W),
        .MAX_HEIGHT(MAP_MAX_H),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    function automatic void note_mismatch(input string what, input longint unsigned want,
                                          input longint unsigned got);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
        end
    endfunction

    // Saturate an index to the last entry of a count-sized image, bounded by the store.
    function automatic longint unsigned clamp_to(input longint unsigned idx,
                                                 input longint unsigned count);
        longint unsigned lim;
        lim = (count > STORE_DEPTH) ? STORE_DEPTH : count;
        lim = (lim == 0) ? 0 : lim - 1;
        return (idx > lim) ? lim : idx;
    endfunction

    // Store indexes read for a coordinate; nearest mode uses only the first.
    function automatic t_taps tap_index(input logic [COORD_W-1:0] cx,
                                        input logic [COORD_W-1:0] cy);
        longint unsigned xi, yi, w, h, raw, d1, d3;
        t_taps t;
        xi = cx >> FRAC;
        yi = cy >> FRAC;
        w = model_cfg.map_width;
        h = model_cfg.map_height;
        if (!model_cfg.interp_enable) begin
            d1 = clamp_to(yi * w + xi, w * h);
            d3 = d1;
            t = {4{ADDR_IN_W'(d1)}};
        end else begin
            raw = yi * 4 * w + 2 * xi;
            d1 = clamp_to(raw, 4 * w * h);
            d3 = clamp_to(raw + 2 * w, 4 * w * h);
            t[0] = ADDR_IN_W'(d1);
            t[1] = ADDR_IN_W'(clamp_to(d1 + 1, 4 * w * h));
            t[2] = ADDR_IN_W'(d3);
            t[3] = ADDR_IN_W'(clamp_to(d3 + 1, 4 * w * h));
        end
        return t;
    endfunction

    // Output pixel: direct lookup, or the four taps blended with 16-bit weights.
    function automatic logic [PIX_W-1:0] blend_pixel(input logic [COORD_W-1:0] cx,
                                                     input logic [COORD_W-1:0] cy,
                                                     input t_taps t);
        longint unsigned one, fx, fy, w1, w2, w3, w4, sum;
        if (!model_cfg.interp_enable) begin
            return src_copy[t[0]];
        end
        one = longint'(1) << FRAC;
        fx = cx & (one - 1);
        fy = cy & (one - 1);
        w1 = ((one - fx) * (one - fy) * WEIGHT_ONE) >> (2 * FRAC);
        w2 = (fx * (one - fy) * WEIGHT_ONE) >> (2 * FRAC);
        w3 = ((one - fx) * fy * WEIGHT_ONE) >> (2 * FRAC);
        w4 = (fx * fy * WEIGHT_ONE) >> (2 * FRAC);
        sum = src_copy[t[0]] * w1 + src_copy[t[1]] * w2 + src_copy[t[2]] * w3
            + src_copy[t[3]] * w4;
        return PIX_W'((sum + ROUND_HALF) >> SUM_SHIFT);
    endfunction

    function automatic t_row row_cfg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        t_row r;
        r = '0;
        r.op = ROW_CFG;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    function automatic t_row row_load(input logic [ADDR_IN_W-1:0] a, input logic [PIX_W-1:0] b);
        t_row r;
        r = '0;
        r.op = ROW_LOAD;
        r.addr = a;
        r.data = b;
        return r;
    endfunction

    function automatic t_row row_remap(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                       input logic typed, input logic [PIX_W-1:0] pix,
                                       input logic [ADDR_IN_W-1:0] base);
        t_row r;
        r = '0;
        r.op = ROW_REMAP;
        r.cx = x;
        r.cy = y;
        r.typed = typed;
        r.pix = pix;
        r.base = base;
        return r;
    endfunction

    // Integer part near the map edge, just past it, at the top of the range, or zero.
    function automatic int edge_pick(input int max_idx);
        case ($urandom_range(3))
            0: return max_idx;
            1: return (max_idx < 255) ? max_idx + 1 : 255;
            2: return 255;
            default: return 0;
        endcase
    endfunction

    // Present one item and hold it until the transfer; gaps come first.
    task automatic send_item(input t_kind kind, input logic [ADDR_IN_W-1:0] addr,
                             input logic [PIX_W-1:0] data, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy);
        int gap;
        int roll;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                burst_left = $urandom_range(30, 120);
            end else if (roll < 55) begin
                gap = 0;
            end else if (roll < 85) begin
                gap = $urandom_range(1, 3);
            end else if (roll < 97) begin
                gap = $urandom_range(4, 12);
            end else begin
                gap = $urandom_range(20, 50);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {7'b0, cy, cx, data, addr};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic put_load(input logic [ADDR_IN_W-1:0] addr, input logic [PIX_W-1:0] data);
        src_copy[addr] = data;
        stored[addr] = 1'b1;
        n_loads++;
        send_item(KIND_LOAD, addr, data, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Any tap not yet loaded gets a byte first, so no read ever hits an unwritten entry.
    task automatic put_remap(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input logic typed, input logic [PIX_W-1:0] pix,
                             input logic [ADDR_IN_W-1:0] base);
        t_taps taps;
        t_result want;
        taps = tap_index(cx, cy);
        for (int k = 0; k < 4; k++) begin
            if (!stored[taps[k]]) begin
                put_load(taps[k], PIX_W'($urandom));
            end
        end
        want.pix = typed ? pix : blend_pixel(cx, cy, taps);
        want.base = typed ? base : taps[0];
        pending_px.push_back(want);
        n_remaps++;
        last_tap = taps[0];
        send_item(KIND_REMAP, ADDR_IN_W'($urandom), PIX_W'($urandom), cx, cy);
    endtask

    // Stop sending and wait for every outstanding pixel plus the pipeline depth.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write followed by a read back of the kept bits.
    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] want;
        want = '0;
        case (idx)
            REG_INTERP: begin
                model_cfg.interp_enable = val[0];
                want[0] = val[0];
            end
            REG_WIDTH: begin
                model_cfg.map_width = val[WIDTH_W-1:0];
                want[WIDTH_W-1:0] = val[WIDTH_W-1:0];
            end
            REG_HEIGHT: begin
                model_cfg.map_height = val[HEIGHT_W-1:0];
                want[HEIGHT_W-1:0] = val[HEIGHT_W-1:0];
            end
            default: ;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            note_mismatch("register read back", want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Output side: random stalls, short and long, with long stretches of no stall.
    initial begin
        int roll;
        int hold;
        m_tready <= 1'b0;
        forever begin
            roll = $urandom_range(99);
            if (roll < 50) begin
                m_tready <= 1'b1;
                hold = $urandom_range(1, 20);
            end else if (roll < 85) begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 3);
            end else if (roll < 95) begin
                m_tready <= 1'b1;
                hold = $urandom_range(50, 150);
            end else begin
                m_tready <= 1'b0;
                hold = $urandom_range(20, 60);
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    // Compare each output transfer with the oldest predicted pixel.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            n_checked++;
            if (pending_px.size() == 0) begin
                note_mismatch("result with none pending", 0, m_tdata);
            end else begin
                want = pending_px.pop_front();
                if (m_tdata[7:0] !== want.pix) begin
                    note_mismatch("out_pixel", want.pix, m_tdata[7:0]);
                end
                if (m_tdata[24:8] !== want.base) begin
                    note_mismatch("base_index", want.base, m_tdata[24:8]);
                end
            end
        end
    end

    initial begin : stimulus
        t_row dir_rows [NUM_DIR];
        int roll;
        int mode;
        int xmax;
        int ymax;
        int xi;
        int yi;
        logic [7:0] fx;
        logic [7:0] fy;
        logic [ADDR_IN_W-1:0] la;

        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= 1'b0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        model_cfg = '{RST_INTERP, RST_WIDTH, RST_HEIGHT};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset settings, coordinate extremes, both modes, zero sizes.
        dir_rows = '{
            row_load(17'd0, 8'hAB),
            row_remap(16'h0000, 16'h0000, 1'b1, 8'd171, 17'd0),
            row_load(17'd131071, 8'hFF),
            row_remap(16'hFFFF, 16'hFFFF, 1'b1, 8'd255, 17'd131071),
            row_remap(16'h0180, 16'h0080, 1'b0, 8'd0, 17'd0),
            row_remap(16'h00FF, 16'h7F01, 1'b0, 8'd0, 17'd0),
            row_cfg(REG_INTERP, 32'd0),
            row_load(17'd1298, 8'h5A),
            row_remap(16'h12FF, 16'h05FF, 1'b1, 8'h5A, 17'd1298),
            row_load(17'd32767, 8'h3C),
            row_remap(16'hFFFF, 16'hFFFF, 1'b1, 8'h3C, 17'd32767),
            row_cfg(REG_WIDTH, 32'd0),
            row_remap(16'h4000, 16'h2000, 1'b1, 8'hAB, 17'd0),
            row_cfg(REG_WIDTH, 32'd511),
            row_cfg(REG_HEIGHT, 32'd255),
            row_remap(16'hFFFF, 16'hFFFF, 1'b0, 8'd0, 17'd0),
            row_cfg(REG_INTERP, 32'd1),
            row_cfg(REG_WIDTH, 32'd1),
            row_cfg(REG_HEIGHT, 32'd1),
            row_remap(16'h0080, 16'h0080, 1'b0, 8'd0, 17'd0),
            row_remap(16'h00FF, 16'h0001, 1'b0, 8'd0, 17'd0),
            row_cfg(REG_HEIGHT, 32'd0),
            row_remap(16'h3380, 16'h0140, 1'b1, 8'hAB, 17'd0),
            row_load(17'd0, 8'h00),
            row_remap(16'h0000, 16'h0000, 1'b1, 8'h00, 17'd0)
        };
        foreach (dir_rows[i]) begin
            case (dir_rows[i].op)
                ROW_CFG: begin
                    settle_idle();
                    set_reg(dir_rows[i].reg_idx, dir_rows[i].value);
                end
                ROW_LOAD: put_load(dir_rows[i].addr, dir_rows[i].data);
                default: put_remap(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].typed,
                                   dir_rows[i].pix, dir_rows[i].base);
            endcase
        end

        // Random part: one register setting per phase, mixed loads and remaps.
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_idle();
            if (p < NUM_FIXED) begin
                set_reg(REG_INTERP, 32'(PHASE_INTERP[p]));
                set_reg(REG_WIDTH, 32'(PHASE_W[p]));
                set_reg(REG_HEIGHT, 32'(PHASE_H[p]));
            end else begin
                set_reg(REG_INTERP, 32'($urandom_range(1)));
                set_reg(REG_WIDTH, 32'($urandom_range(1, MAP_MAX_W)));
                set_reg(REG_HEIGHT, 32'($urandom_range(1, MAP_MAX_H)));
            end
            n_settings++;
            xmax = (model_cfg.map_width == 0) ? 0
                 : ((model_cfg.map_width > 256) ? 255 : int'(model_cfg.map_width) - 1);
            ymax = (model_cfg.map_height == 0) ? 0 : int'(model_cfg.map_height) - 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 2) begin
                    settle_idle();
                end else if (roll < 32) begin
                    // Loads land anywhere, or just after the last tap read.
                    if ($urandom_range(9) < 4) begin
                        la = ADDR_IN_W'($urandom);
                    end else begin
                        la = last_tap + ADDR_IN_W'($urandom_range(2 * xmax + 3));
                    end
                    put_load(la, PIX_W'($urandom));
                end else begin
                    mode = $urandom_range(99);
                    fx = 8'($urandom);
                    fy = 8'($urandom);
                    if (mode < 20) begin
                        xi = $urandom_range(255);
                        yi = $urandom_range(255);
                    end else if (mode < 70) begin
                        xi = $urandom_range(xmax);
                        yi = $urandom_range(ymax);
                    end else if (mode < 85) begin
                        xi = $urandom_range(xmax);
                        yi = $urandom_range(ymax);
                        fx = $urandom_range(1) ? 8'hFF : 8'h00;
                        fy = $urandom_range(1) ? 8'hFF : 8'h00;
                    end else begin
                        xi = edge_pick(xmax);
                        yi = edge_pick(ymax);
                    end
                    put_remap({8'(xi), fx}, {8'(yi), fy}, 1'b0, 8'd0, 17'd0);
                end
            end
        end

        settle_idle();
        $display("Ran %0d loads and %0d remaps over %0d random register settings,",
                 n_loads, n_remaps, n_settings);
        $display("both lookup modes, zero and oversized maps; %0d pixels compared.", n_checked);
        if (n_mismatch == 0 && pending_px.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
